### rtl/pbx_pkg.sv
// ----------------------------------------------------------------------------
// pbx_pkg
// Shared types and constants of the protection-header box payload extractor:
// parse phases, the wanted box type and system id, and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbx_pkg;

  // Parse phase of the box walker
  typedef enum logic [3:0] {
    PH_SIZE    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_EXT     = 4'd2,
    PH_VER     = 4'd3,
    PH_FLAGS   = 4'd4,
    PH_SYSID   = 4'd5,
    PH_KIDCNT  = 4'd6,
    PH_KIDSKIP = 4'd7,
    PH_DLEN    = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_SKIP    = 4'd10
  } parse_phase_e;

  // Field lengths in bytes
  localparam logic [4:0] SIZE_LEN   = 5'd4;
  localparam logic [4:0] TYPE_LEN   = 5'd4;
  localparam logic [4:0] EXT_LEN    = 5'd8;
  localparam logic [4:0] FLAGS_LEN  = 5'd3;
  localparam logic [4:0] SYSID_LEN  = 5'd16;
  localparam logic [4:0] KIDCNT_LEN = 5'd4;
  localparam logic [4:0] DLEN_LEN   = 5'd4;

  // Box type "pssh"
  localparam logic [7:0] BOX_TYPE [4] = '{8'h70, 8'h73, 8'h73, 8'h68};

  // System id 9A04F079-9840-4286-AB92-E65BE0885F95
  localparam logic [7:0] SYSTEM_ID [16] = '{
    8'h9A, 8'h04, 8'hF0, 8'h79, 8'h98, 8'h40, 8'h42, 8'h86,
    8'hAB, 8'h92, 8'hE6, 8'h5B, 8'hE0, 8'h88, 8'h5F, 8'h95
  };

  // Version codes
  localparam logic [7:0] VERSION_0 = 8'd0;
  localparam logic [7:0] VERSION_1 = 8'd1;

  // One processed byte as seen by the result register
  typedef struct packed {
    logic       has_result;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       search_done;
    logic       box_found;
  } pbx_result_t;

endpackage

### rtl/pbx_in_stage.sv
// ----------------------------------------------------------------------------
// pbx_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbx_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       take_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o,
  output logic       held_final_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       final_q;

  // Free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      final_q <= final_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;
  assign held_final_o = final_q;

endmodule

### rtl/pbx_parser.sv
// ----------------------------------------------------------------------------
// pbx_parser
// Box walker: updates size, consumed and skip counters for each byte and
// decides whether the byte yields a payload byte or ends the search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbx_parser #(
  parameter int SIZE_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output pbx_pkg::pbx_result_t result_o
);

  import pbx_pkg::*;

  // Skip counter must hold key-id count times 16 (36 bits) or a box remainder
  localparam int SkipWidth = (SIZE_WIDTH > 36) ? SIZE_WIDTH : 36;

  parse_phase_e           phase_q, phase_d;
  logic [4:0]             cnt_q, cnt_d;
  logic [SIZE_WIDTH-1:0]  size_q, size_d;
  logic [SIZE_WIDTH-1:0]  cons_q, cons_d;
  logic [SkipWidth-1:0]   skip_q, skip_d;
  logic [7:0]             ver_q, ver_d;
  logic                   match_q, match_d;
  logic                   fin_q, fin_d;

  logic [4:0]             cnt_inc;
  logic [SIZE_WIDTH-1:0]  rem;
  logic [35:0]            field36;
  logic [31:0]            field32;
  logic                   valid, done, found, bad, req_skip, go_size;

  assign cnt_inc = cnt_q + 5'd1;
  assign field32 = {skip_q[23:0], data_byte_i};
  assign field36 = {field32, 4'b0000};
  assign rem     = size_d - cons_d;

  // Next state for one byte
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    size_d   = size_q;
    cons_d   = cons_q;
    skip_d   = skip_q;
    ver_d    = ver_q;
    match_d  = match_q;
    fin_d    = fin_q;
    valid    = 1'b0;
    done     = 1'b0;
    found    = 1'b0;
    bad      = 1'b0;
    req_skip = 1'b0;
    go_size  = 1'b0;

    if (fin_q) begin
      // Search over: drop bytes until the end of the block
      if (final_byte_i) begin
        fin_d   = 1'b0;
        go_size = 1'b1;
      end
    end else begin
      if (cons_q != '1) cons_d = cons_q + 1'b1;

      unique case (phase_q)
        PH_SIZE: begin
          size_d = SIZE_WIDTH'({size_q[23:0], data_byte_i});
          cnt_d  = cnt_inc;
          if (cnt_inc >= SIZE_LEN) begin
            cnt_d   = '0;
            match_d = 1'b1;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (data_byte_i != BOX_TYPE[cnt_q[1:0]]) match_d = 1'b0;
          cnt_d = cnt_inc;
          if (cnt_inc >= TYPE_LEN) begin
            cnt_d = '0;
            if (size_q == SIZE_WIDTH'(1)) begin
              size_d  = '0;
              phase_d = PH_EXT;
            end else begin
              if (size_q == '0) size_d = '1;
              if (!match_d) req_skip = 1'b1;
              else          phase_d  = PH_VER;
            end
          end
        end
        PH_EXT: begin
          // Saturate a 64-bit size that does not fit
          if (|size_q[SIZE_WIDTH-1 -: 8]) size_d = '1;
          else                            size_d = {size_q[SIZE_WIDTH-9:0], data_byte_i};
          cnt_d = cnt_inc;
          if (cnt_inc >= EXT_LEN) begin
            cnt_d = '0;
            if (!match_q) req_skip = 1'b1;
            else          phase_d  = PH_VER;
          end
        end
        PH_VER: begin
          ver_d = data_byte_i;
          cnt_d = '0;
          if (data_byte_i > VERSION_1) req_skip = 1'b1;
          else                         phase_d  = PH_FLAGS;
        end
        PH_FLAGS: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= FLAGS_LEN) begin
            cnt_d   = '0;
            match_d = 1'b1;
            phase_d = PH_SYSID;
          end
        end
        PH_SYSID: begin
          if (data_byte_i != SYSTEM_ID[cnt_q[3:0]]) match_d = 1'b0;
          cnt_d = cnt_inc;
          if (cnt_inc >= SYSID_LEN) begin
            cnt_d  = '0;
            skip_d = '0;
            if (!match_d)                req_skip = 1'b1;
            else if (ver_q == VERSION_1) phase_d  = PH_KIDCNT;
            else                         phase_d  = PH_DLEN;
          end
        end
        PH_KIDCNT: begin
          skip_d = SkipWidth'(field32);
          cnt_d  = cnt_inc;
          if (cnt_inc >= KIDCNT_LEN) begin
            cnt_d   = '0;
            skip_d  = SkipWidth'(field36);
            phase_d = (field36 != '0) ? PH_KIDSKIP : PH_DLEN;
          end
        end
        PH_KIDSKIP: begin
          if (skip_q != '0) skip_d = skip_q - 1'b1;
          if (skip_d == '0) begin
            cnt_d   = '0;
            phase_d = PH_DLEN;
          end
        end
        PH_DLEN: begin
          skip_d = SkipWidth'(field32);
          cnt_d  = cnt_inc;
          if (cnt_inc >= DLEN_LEN) begin
            cnt_d = '0;
            if (field32 == '0) begin
              done  = 1'b1;
              found = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          valid = 1'b1;
          if (skip_q != '0) skip_d = skip_q - 1'b1;
          if (skip_d == '0) begin
            done  = 1'b1;
            found = 1'b1;
          end
        end
        default: begin
          // Skipping the body of an unwanted box
          if (skip_q != '0) skip_d = skip_q - 1'b1;
          if (skip_d == '0) go_size = 1'b1;
        end
      endcase

      // Skip the rest of the current box, fail if its size is too small
      if (req_skip) begin
        if (size_d < cons_d) begin
          bad = 1'b1;
        end else if (rem == '0) begin
          go_size = 1'b1;
        end else begin
          skip_d  = SkipWidth'(rem);
          phase_d = PH_SKIP;
        end
      end

      if (bad || final_byte_i) done = 1'b1;

      if (done) begin
        if (final_byte_i) begin
          fin_d   = 1'b0;
          go_size = 1'b1;
        end else begin
          fin_d = 1'b1;
        end
      end
    end

    // Start of a new box header
    if (go_size) begin
      phase_d = PH_SIZE;
      cnt_d   = '0;
      size_d  = '0;
      cons_d  = '0;
      skip_d  = '0;
      match_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      cnt_q   <= '0;
      size_q  <= '0;
      cons_q  <= '0;
      skip_q  <= '0;
      ver_q   <= '0;
      match_q <= 1'b1;
      fin_q   <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
      cons_q  <= cons_d;
      skip_q  <= skip_d;
      ver_q   <= ver_d;
      match_q <= match_d;
      fin_q   <= fin_d;
    end
  end

  // Result of this byte
  assign result_o.has_result    = valid || done;
  assign result_o.payload_byte  = valid ? data_byte_i : 8'd0;
  assign result_o.payload_valid = valid;
  assign result_o.search_done   = done;
  assign result_o.box_found     = done && found;

endmodule

### rtl/pbx_out_stage.sv
// ----------------------------------------------------------------------------
// pbx_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbx_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  pbx_pkg::pbx_result_t result_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           payload_byte_o,
  output logic                 payload_valid_o,
  output logic                 search_done_o,
  output logic                 box_found_o
);

  import pbx_pkg::*;

  logic        valid_q, valid_d;
  logic        load;
  pbx_result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign load    = take_i && result_i.has_result;
  assign valid_d = load || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_valid_o = res_q.payload_valid;
  assign search_done_o   = res_q.search_done;
  assign box_found_o     = res_q.box_found;

endmodule

### rtl/pssh_box_payload_extractor.sv
// A byte waits in the input register until the result register is free to take it.
// Throughput: one byte per cycle while the output side keeps taking results.
// The input register and the result register set that figure; the counters
// and compares of the box walker sit combinationally between them.
// Reset (rst_ni low, asynchronous) returns the walker to the box size phase
// and empties both registers; no clearing pass follows.
// ----------------------------------------------------------------------------
// pssh_box_payload_extractor
// Walks a byte stream of ISO-BMFF boxes and streams out the payload of the
// first protection-header box with the wanted system id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pssh_box_payload_extractor #(
  parameter int SIZE_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic       search_done_o,
  output logic       box_found_o
);

  import pbx_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        held_final;
  logic        out_free;
  logic        take;
  pbx_result_t result;

  // A held byte moves on when the result register can take its result
  assign take = held_valid && out_free;

  pbx_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .take_i       (take),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte),
    .held_final_o (held_final)
  );

  pbx_parser #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (held_byte),
    .final_byte_i (held_final),
    .result_o     (result)
  );

  pbx_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .result_i        (result),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .search_done_o   (search_done_o),
    .box_found_o     (box_found_o)
  );

endmodule

### rtl/pbx_checker.sv
// ----------------------------------------------------------------------------
// pbx_checker
// Port-level checks of the extractor's result channel and input handshake, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       final_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       payload_valid_o,
  input logic       search_done_o,
  input logic       box_found_o
);

  // Every result carries a payload byte or ends the search
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_valid_o || search_done_o))
    else $error("result with neither payload nor completion");

  // Found is only reported together with completion
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && box_found_o) |-> search_done_o)
    else $error("box_found without search_done");

  // A completion-only result shows a zero byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_byte_o == 8'd0))
    else $error("payload byte not zero without payload_valid");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(payload_byte_o) && $stable(search_done_o)))
    else $error("stalled result changed");

  // A waiting request holds its byte and mark
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(data_byte_i) && $stable(final_byte_i)))
    else $error("waiting request changed");

endmodule

bind pssh_box_payload_extractor pbx_checker u_pbx_checker (.*);
